### sv/dcfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the drive command frame parser.
// Used by every module of the block; depends on nothing.
package dcfp_pkg;

  localparam int          SLOT_COUNT = 4;
  localparam int          RADIX      = 10;

  localparam logic [7:0]  BYTE_OPEN  = 8'h6E;  // 'n'
  localparam logic [7:0]  BYTE_CLOSE = 8'h68;  // 'h'
  localparam logic [7:0]  BYTE_ZERO  = 8'h30;  // '0'
  localparam logic [7:0]  BYTE_NINE  = 8'h39;  // '9'

  localparam logic [2:0]  SLOT_FIRST = 3'd1;
  localparam logic [2:0]  SLOT_LAST  = 3'(SLOT_COUNT);

  typedef logic [3:0]        digit_t;
  typedef logic signed [7:0] speed_t;

  typedef enum logic [6:0] {
    MODE_STOP     = 7'd0,
    MODE_X_POS    = 7'd1,
    MODE_X_NEG    = 7'd2,
    MODE_Y_POS    = 7'd3,
    MODE_Y_NEG    = 7'd4,
    MODE_TURN_POS = 7'd5,
    MODE_TURN_NEG = 7'd6
  } mode_t;

  // Contents of the input register handed to the decode core.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

endpackage

### sv/dcfp_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one received byte per item.
// Stands alone; used by the input stage and the top level.
interface dcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/dcfp_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one decoded drive command per item.
// Stands alone; used by the decode core and the top level.
interface dcfp_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] speed_x;
  logic signed [7:0] speed_y;
  logic signed [7:0] speed_turn;
  logic              mode_known;

  modport source (output valid, output speed_x, output speed_y, output speed_turn,
                  output mode_known, input ready);
  modport sink   (input valid, input speed_x, input speed_y, input speed_turn,
                  input mode_known, output ready);
endinterface

### sv/dcfp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the frame parser: captures one byte per item from the channel.
// Depends on dcfp_pkg and dcfp_in_if.
module dcfp_in_stage import dcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dcfp_in_if.sink    rx,
  input  logic       take,
  output stage_t     stage
);

  logic       held_valid;
  logic [7:0] held_byte;

  // The register can reload in the same cycle that the core consumes it.
  assign rx.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

  assign stage.valid   = held_valid;
  assign stage.rx_byte = held_byte;

endmodule

### sv/dcfp_core.sv
`timescale 1ns / 1ps
// Frame state, digit slots, command decode and the result register of the parser.
// Depends on dcfp_pkg and dcfp_out_if.
module dcfp_core import dcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  stage_t     stage,
  output logic       take,
  dcfp_out_if.source cmd
);

  logic        frame_open;
  logic [2:0]  slot_index;
  digit_t      digit_slots [SLOT_COUNT];
  speed_t      held_x;
  speed_t      held_y;
  speed_t      held_turn;
  logic        mode_known;
  logic        out_valid;

  logic        is_open;
  logic        is_close;
  logic        is_digit;
  logic        slot_free;
  logic        store;
  logic        out_free;
  logic [2:0]  slot_ptr;
  digit_t      digit;
  logic [6:0]  mode_val;
  logic [6:0]  speed_val;
  speed_t      speed_pos;
  speed_t      speed_neg;
  speed_t      held_x_next;
  speed_t      held_y_next;
  speed_t      held_turn_next;
  logic        mode_known_next;

  always_comb begin
    is_open   = stage.rx_byte == BYTE_OPEN;
    is_close  = stage.rx_byte == BYTE_CLOSE;
    is_digit  = stage.rx_byte inside {[BYTE_ZERO:BYTE_NINE]};
    slot_free = slot_index inside {[SLOT_FIRST:SLOT_LAST]};
    out_free  = !out_valid || cmd.ready;
    // A closing byte waits only while an earlier result is still unclaimed.
    take      = stage.valid && (!is_close || out_free);
    store     = take && !is_open && !is_close && frame_open && is_digit && slot_free;
    slot_ptr  = slot_index - SLOT_FIRST;
    digit     = digit_t'(stage.rx_byte - BYTE_ZERO);
  end

  always_comb begin
    mode_val  = 7'(digit_slots[0]) * 7'(RADIX) + 7'(digit_slots[1]);
    speed_val = 7'(digit_slots[2]) * 7'(RADIX) + 7'(digit_slots[3]);
    speed_pos = {1'b0, speed_val};
    speed_neg = -speed_pos;

    held_x_next     = held_x;
    held_y_next     = held_y;
    held_turn_next  = held_turn;
    mode_known_next = 1'b1;
    case (mode_t'(mode_val))
      MODE_STOP: begin
        held_x_next    = '0;
        held_y_next    = '0;
        held_turn_next = '0;
      end
      MODE_X_POS: begin
        held_x_next    = speed_pos;
        held_y_next    = '0;
        held_turn_next = '0;
      end
      MODE_X_NEG: begin
        held_x_next    = speed_neg;
        held_y_next    = '0;
        held_turn_next = '0;
      end
      MODE_Y_POS: begin
        held_x_next    = '0;
        held_y_next    = speed_pos;
        held_turn_next = '0;
      end
      MODE_Y_NEG: begin
        held_x_next    = '0;
        held_y_next    = speed_neg;
        held_turn_next = '0;
      end
      MODE_TURN_POS: begin
        held_x_next    = '0;
        held_y_next    = '0;
        held_turn_next = speed_pos;
      end
      MODE_TURN_NEG: begin
        held_x_next    = '0;
        held_y_next    = '0;
        held_turn_next = speed_neg;
      end
      default: begin
        mode_known_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      slot_index <= SLOT_FIRST;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        digit_slots[k] <= '0;
      end
      held_x     <= '0;
      held_y     <= '0;
      held_turn  <= '0;
      mode_known <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take && is_open) begin
        frame_open <= 1'b1;
      end else if (take && is_close) begin
        frame_open <= 1'b0;
        slot_index <= SLOT_FIRST;
        held_x     <= held_x_next;
        held_y     <= held_y_next;
        held_turn  <= held_turn_next;
        mode_known <= mode_known_next;
      end else if (store) begin
        digit_slots[slot_ptr[1:0]] <= digit;
        slot_index                 <= slot_index + 3'd1;
      end

      if (take && is_close) begin
        out_valid <= 1'b1;
      end else if (cmd.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The held velocities only change when a new result is loaded, so they
  // serve directly as the result register.
  assign cmd.valid      = out_valid;
  assign cmd.speed_x    = held_x;
  assign cmd.speed_y    = held_y;
  assign cmd.speed_turn = held_turn;
  assign cmd.mode_known = mode_known;

`ifndef SYNTH
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_index >= SLOT_FIRST && slot_index <= SLOT_LAST + 3'd1)
    else $error("slot index out of range");

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    take && is_close |=> slot_index == SLOT_FIRST && !frame_open && out_valid)
    else $error("closing byte did not reset the frame and load a result");

  a_unknown_keeps: assert property (@(posedge clk) disable iff (rst)
    take && is_close && !mode_known_next |=>
      $stable(held_x) && $stable(held_y) && $stable(held_turn))
    else $error("unknown mode changed the held velocities");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cmd.ready |-> !(take && is_close))
    else $error("result overwritten before it was taken");
`endif

endmodule

### sv/drive_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the drive command frame parser: input register followed by the decode core.
// Depends on dcfp_pkg, dcfp_in_if, dcfp_out_if, dcfp_in_stage and dcfp_core.

// The parser accepts one received byte per item and can take a new byte in every
// clock cycle. Bytes pass through an input register into the decode core, which
// updates the frame state and, for each closing 'h', loads a command into its
// result register. A command appears after its 'h' has passed the input register
// and the result register, later if the 'h' has to wait. Only the result register
// can hold the input back: a closing byte waits in the input register while the previous
// command is still unclaimed, and every other byte is absorbed at once. Modes 0 to 6 set
// the held velocities; any other mode returns the old ones with mode_known low.
module drive_command_frame_parser_unit import dcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dcfp_in_if.sink    rx,
  dcfp_out_if.source cmd
);

  stage_t stage;
  logic   take;

  dcfp_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  dcfp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .take  (take),
    .cmd   (cmd)
  );

endmodule

### tb/dcfp_cmd_monitor.sv
`timescale 1ns / 1ps
// Watches both channels of the drive command frame parser, predicts each command from the
// accepted bytes and compares it with what the block returns. Depends on dcfp_pkg and the
// dcfp_in_if and dcfp_out_if interfaces.
module dcfp_cmd_monitor import dcfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  dcfp_in_if   rx,
  dcfp_out_if  cmd,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    speed_t x;
    speed_t y;
    speed_t turn;
    logic   known;
  } drive_cmd_t;

  drive_cmd_t expected_cmds[$];
  drive_cmd_t oldest_cmd;

  logic       frame_open;
  logic [2:0] next_slot;
  digit_t     digits[SLOT_COUNT];
  speed_t     held_x;
  speed_t     held_y;
  speed_t     held_turn;

  initial errors = 0;

  // Updates the parser state for one received byte and queues a command on each close.
  task automatic absorb_byte(input logic [7:0] b);
    logic [6:0] mode;
    speed_t     speed;
    drive_cmd_t c;
    if (b == BYTE_OPEN) begin
      frame_open = 1'b1;
    end else if (b == BYTE_CLOSE) begin
      next_slot  = SLOT_FIRST;
      frame_open = 1'b0;
      mode  = 7'(int'(digits[0]) * RADIX + int'(digits[1]));
      speed = 8'(int'(digits[2]) * RADIX + int'(digits[3]));
      c.known = 1'b1;
      case (mode)
        MODE_STOP: begin
          held_x = 0; held_y = 0; held_turn = 0;
        end
        MODE_X_POS: begin
          held_x = speed; held_y = 0; held_turn = 0;
        end
        MODE_X_NEG: begin
          held_x = -speed; held_y = 0; held_turn = 0;
        end
        MODE_Y_POS: begin
          held_x = 0; held_y = speed; held_turn = 0;
        end
        MODE_Y_NEG: begin
          held_x = 0; held_y = -speed; held_turn = 0;
        end
        MODE_TURN_POS: begin
          held_x = 0; held_y = 0; held_turn = speed;
        end
        MODE_TURN_NEG: begin
          held_x = 0; held_y = 0; held_turn = -speed;
        end
        default: begin
          // An unknown mode leaves the velocities as they were.
          c.known = 1'b0;
        end
      endcase
      c.x    = held_x;
      c.y    = held_y;
      c.turn = held_turn;
      expected_cmds.push_back(c);
    end else if (frame_open && b >= BYTE_ZERO && b <= BYTE_NINE && next_slot <= SLOT_LAST) begin
      digits[2'(next_slot - SLOT_FIRST)] = 4'(b - BYTE_ZERO);
      next_slot = next_slot + 3'd1;
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frame_open = 1'b0;
      next_slot  = SLOT_FIRST;
      for (int k = 0; k < SLOT_COUNT; k++) digits[k] = '0;
      held_x    = 0;
      held_y    = 0;
      held_turn = 0;
      expected_cmds.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("command item returned with none expected");
          errors++;
        end else begin
          oldest_cmd = expected_cmds.pop_front();
          check_field("speed_x", oldest_cmd.x, cmd.speed_x);
          check_field("speed_y", oldest_cmd.y, cmd.speed_y);
          check_field("speed_turn", oldest_cmd.turn, cmd.speed_turn);
          check_field("mode_known", int'(oldest_cmd.known), int'(cmd.mode_known));
        end
      end
      if (rx.valid && rx.ready) absorb_byte(rx.rx_byte);
    end
    pending <= expected_cmds.size();
  end

endmodule

### tb/tb_drive_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// Top of the drive command frame parser testbench: clock, reset, byte stimulus, receiver
// back-pressure and the verdict. Depends on dcfp_pkg, both channel interfaces, the block
// and dcfp_cmd_monitor.
module tb_drive_command_frame_parser_unit;
  import dcfp_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 300;

  logic clk = 1'b0;
  logic rst;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int errors;
  int pending;

  dcfp_in_if  rx_ch ();
  dcfp_out_if cmd_ch ();

  drive_command_frame_parser_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cmd (cmd_ch)
  );

  dcfp_cmd_monitor cmd_monitor (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .cmd     (cmd_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #4 clk = ~clk;

  // Ends the run if the block stops moving items altogether.
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("drive_command_frame_parser_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    cmd_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        cmd_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cmd_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (b == BYTE_OPEN || b == BYTE_CLOSE || (b >= BYTE_ZERO && b <= BYTE_NINE)) items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the sender back until every queued command has come out.
  task automatic wait_for_commands();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A frame with random digits; the first digit leans towards zero so that most modes are
  // known. Repeated opens and stray bytes are mixed in now and then.
  task automatic send_random_frame(input bit broken);
    int n_digits;
    int d;
    send_byte(BYTE_OPEN);
    n_digits = ($urandom_range(3) != 0) ? 4 : $urandom_range(6);
    for (int i = 0; i < n_digits; i++) begin
      if ($urandom_range(15) == 0) send_byte(BYTE_OPEN);
      if ($urandom_range(15) == 0) send_byte(8'($urandom_range(255)));
      if (i == 0 && $urandom_range(4) != 0) d = 0;
      else d = $urandom_range(9);
      send_byte(BYTE_ZERO + 8'(d));
    end
    if (!broken) send_byte(BYTE_CLOSE);
  endtask

  task automatic send_random_items(input int quota);
    int first;
    first = items_sent;
    while (items_sent - first < quota) begin
      case ($urandom_range(9))
        0:       send_byte(8'($urandom_range(255)));
        1:       send_random_frame(1'b1);
        default: send_random_frame(1'b0);
      endcase
    end
  endtask

  initial begin
    rst <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Close before any open, then byte extremes and a digit outside a frame.
    send_text("h");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("7");
    // Every mode; short frames reuse stale speed digits, one repeats the open, one has an
    // extra digit, and the last two give an unknown mode and a stop.
    send_text("n0199h");
    send_text("n02h");
    send_text("n0n3h");
    send_text("n04005h");
    send_text("n05h");
    send_text("n069h");
    send_text("n99h");
    send_text("n00h");
    wait_for_commands();

    send_idle_pct = 19;
    recv_idle_pct = 87;
    send_random_items(PHASE_ITEMS);
    wait_for_commands();

    send_idle_pct = 87;
    recv_idle_pct = 19;
    send_random_items(PHASE_ITEMS);
    wait_for_commands();

    // No idling; the long receiver hold-off makes the input stall behind a pending close.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random_items(PHASE_ITEMS);
    wait_for_commands();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("drive_command_frame_parser_unit: match");
    end else begin
      $display("drive_command_frame_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
